// ===== src/roiu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank-one inverse update package
// Shared widths, codes and Q16.16 rounding and saturation helpers.
// ----------------------------------------------------------------------------
package roiu_pkg;

	localparam int DIM_DEF = 16;
	localparam int IDX_W = 4;
	localparam int VAL_W = 32;
	localparam int OP_W = 3;
	localparam int STAT_W = 2;
	localparam int IN_DATA_W = 112;
	localparam int OUT_DATA_W = 64;
	localparam int DIV_DVD_W = 48;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE_ENTRY = 3'd0,
		OP_WRITE_DET   = 3'd1,
		OP_SINGLE      = 3'd2,
		OP_DOUBLE      = 3'd3,
		OP_READ        = 3'd4
	} op_t;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
	localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;

	// Round half up at the Q16.16 point: floor((v + 2^15) / 2^16).
	function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + 64'sd32768;
		return t >>> 16;
	endfunction

	// Clamp to 32 bits; the top bit of the result marks a clamp.
	function automatic logic [32:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return {1'b1, 32'h7fff_ffff};
		end else if (v < -64'sd2147483648) begin
			return {1'b1, 32'h8000_0000};
		end
		return {1'b0, v[31:0]};
	endfunction

endpackage

// ===== src/roiu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module roiu_ram #(
	parameter int W = 32,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/roiu_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scale divider
// Restoring divider for delta * 2^16 / d, truncated toward zero, clamped.
// ----------------------------------------------------------------------------
module roiu_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [roiu_pkg::VAL_W-1:0] num,
	input  logic signed [roiu_pkg::VAL_W-1:0] den,
	output logic                           done,
	output logic signed [roiu_pkg::VAL_W-1:0] quot,
	output logic                           ovf
);
	import roiu_pkg::*;

	logic                 run_q;
	logic                 done_q;
	logic [5:0]           cnt_q;
	logic [DIV_DVD_W-1:0] dvd_q;
	logic [DIV_DVD_W-1:0] quot_q;
	logic [VAL_W-1:0]     rem_q;
	logic [VAL_W-1:0]     den_q;
	logic                 neg_q;
	logic [VAL_W:0]       trial;
	logic                 fits;
	logic [VAL_W-1:0]     num_abs;
	logic [VAL_W-1:0]     den_abs;

	assign num_abs = num[VAL_W-1] ? VAL_W'(-num) : VAL_W'(num);
	assign den_abs = den[VAL_W-1] ? VAL_W'(-den) : VAL_W'(den);
	assign trial = {rem_q, dvd_q[DIV_DVD_W-1]};
	assign fits = trial >= {1'b0, den_q};

	// One quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'(DIV_DVD_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath of the divider.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num_abs, 16'h0000};
			den_q <= den_abs;
			rem_q <= '0;
			quot_q <= '0;
			neg_q <= num[VAL_W-1] ^ den[VAL_W-1];
		end else if (run_q) begin
			dvd_q <= {dvd_q[DIV_DVD_W-2:0], 1'b0};
			quot_q <= {quot_q[DIV_DVD_W-2:0], fits};
			rem_q <= fits ? VAL_W'(trial - {1'b0, den_q}) : trial[VAL_W-1:0];
		end
	end

	// Sign and clamp of the finished quotient.
	always_comb begin
		ovf = 1'b0;
		if (!neg_q) begin
			quot = quot_q[VAL_W-1:0];
			if (quot_q > 48'd2147483647) begin
				ovf = 1'b1;
				quot = 32'sh7fff_ffff;
			end
		end else begin
			quot = VAL_W'(-quot_q);
			if (quot_q > 48'd2147483648) begin
				ovf = 1'b1;
				quot = 32'sh8000_0000;
			end
		end
	end

	assign done = done_q;

endmodule

// ===== src/rank_one_inverse_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank-one inverse update
// Keeps a DIM x DIM Q16.16 inverse and its determinant under rank-one updates.
// ----------------------------------------------------------------------------
// Usage: one command beat enters on the s_ channel (op in s_tuser) and one
// result beat leaves on the m_ channel (read value and determinant in
// m_tdata, status in m_tuser). s_tready is high only while the sequencer is
// idle; a finished result sits in the output register, so the next command
// is taken while the receiver stalls, and it only waits at its own end.
// Writes, determinant writes and out-of-range commands go through dispatch
// straight to the finish state; a read waits for the RAM read data first.
// An update step runs through one shared 32x32 multiplier and the matrix
// RAM: it forms the divisor, runs the bit-serial scale divider, copies
// column and row into buffers, rewrites every entry and then updates the
// determinant. A double update adds a check of the second divisor and then
// a second step. Reset clears the determinant and the sequencer; the matrix
// stays undefined until written.
// ----------------------------------------------------------------------------
module rank_one_inverse_update #(
	parameter int DIM = roiu_pkg::DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// row_index[3:0], col_index[7:4], second_col_index[11:8], write_value[43:12],
	// first_delta[75:44], second_delta[107:76], zero pad[111:108]
	input  logic [roiu_pkg::IN_DATA_W-1:0]    s_tdata,
	// op[2:0]
	input  logic [roiu_pkg::OP_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// read_value[31:0], determinant[63:32]
	output logic [roiu_pkg::OUT_DATA_W-1:0]   m_tdata,
	// status[1:0]
	output logic [roiu_pkg::STAT_W-1:0]       m_tuser
);
	import roiu_pkg::*;

	localparam int IW = $clog2(DIM);
	localparam int AW = $clog2(DIM * DIM);
	localparam logic [IW-1:0] LAST = IW'(DIM - 1);

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_RDW, S_DRD, S_DMUL, S_DCHK, S_DIV,
		S_PRD, S_PM1, S_PM2, S_PM3, S_PM4, S_PM5, S_PM6,
		S_CRD, S_CWR, S_ARD, S_AMUL, S_ASAT, S_ERD, S_EMUL, S_EWR,
		S_DET, S_DETW, S_FIN
	} state_t;

	state_t state_q;

	// Command registers.
	logic [OP_W-1:0]        op_q;
	logic                   range_q;
	logic [IW-1:0]          i_q, col_q, k_q, j_q;
	logic signed [VAL_W-1:0] wv_q, d2_q, delta_q;
	logic                   second_q;

	// Working registers.
	logic signed [VAL_W-1:0] det_q, d_q, s_q, a_q, mji_q, mki_q, m1_q;
	logic signed [63:0]      prod_q;
	logic                    sat_q, half_q;
	logic [IW-1:0]           r_q, c_q, cnt_q;

	// Output register.
	logic                    ovalid_q;
	logic signed [VAL_W-1:0] rv_q, orv_q, odet_q;
	logic [STAT_W-1:0]       ost_q, st_q;

	// Memory ports.
	logic                    mem_we, mem_re, col_we, col_re, row_we, row_re;
	logic [AW-1:0]           mem_waddr, mem_raddr;
	logic [VAL_W-1:0]        mem_wdata, mrd, crd, rrd;
	logic [IW-1:0]           col_raddr, row_raddr;

	// Shared multiplier and derived values.
	logic signed [VAL_W-1:0] ma, mb;
	logic [32:0]             dsat, psat, esat, lsat;
	logic                    div_start, div_done, div_ovf;
	logic signed [VAL_W-1:0] div_quot;
	logic                    in_range;

	function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
		return AW'(r) * AW'(DIM) + AW'(c);
	endfunction

	roiu_ram #(.W(VAL_W), .D(DIM * DIM)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.re(mem_re), .raddr(mem_raddr), .rdata(mrd)
	);

	roiu_ram #(.W(VAL_W), .D(DIM)) u_col (
		.clk(clk), .we(col_we), .waddr(cnt_q), .wdata(mrd),
		.re(col_re), .raddr(col_raddr), .rdata(crd)
	);

	roiu_ram #(.W(VAL_W), .D(DIM)) u_row (
		.clk(clk), .we(row_we), .waddr(cnt_q), .wdata(mrd),
		.re(row_re), .raddr(row_raddr), .rdata(rrd)
	);

	roiu_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(delta_q), .den(dsat[31:0]),
		.done(div_done), .quot(div_quot), .ovf(div_ovf)
	);

	assign s_tready = (state_q == S_IDLE);
	assign in_range = (int'(s_tdata[3:0]) < DIM) && (int'(s_tdata[7:4]) < DIM) &&
		((s_tuser != OP_DOUBLE) || (int'(s_tdata[11:8]) < DIM));

	// Divisor, scale product and entry update values from the product register.
	assign dsat = sat32(rnd16(64'sh1_0000_0000 + prod_q));
	assign psat = sat32(rnd16(prod_q));
	assign esat = sat32(64'(signed'(mrd)) - rnd16(prod_q));
	assign lsat = sat32(64'(mki_q) - rnd16(prod_q));
	assign div_start = (state_q == S_DCHK) && (dsat[31:0] != 32'h0);

	// Multiplier operand selection.
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_DMUL: begin ma = delta_q; mb = mrd; end
			S_PM1:  begin ma = s_q;     mb = mrd; end
			S_PM3:  begin ma = a_q;     mb = mji_q; end
			S_PM5:  begin ma = d2_q;    mb = m1_q; end
			S_AMUL: begin ma = s_q;     mb = crd; end
			S_EMUL: begin ma = a_q;     mb = rrd; end
			S_DET:  begin ma = det_q;   mb = d_q; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	// Memory port control.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = addr_of(r_q, c_q);
		mem_wdata = esat[31:0];
		mem_re = 1'b0;
		mem_raddr = addr_of(r_q, c_q);
		col_we = 1'b0;
		row_we = 1'b0;
		col_re = 1'b0;
		row_re = 1'b0;
		col_raddr = r_q;
		row_raddr = c_q;
		case (state_q)
			S_DISP: begin
				mem_waddr = addr_of(i_q, col_q);
				mem_wdata = wv_q;
				mem_we = range_q && (op_q == OP_WRITE_ENTRY);
				mem_raddr = addr_of(i_q, col_q);
				mem_re = range_q && (op_q == OP_READ);
			end
			S_DRD: begin
				mem_re = 1'b1;
				mem_raddr = addr_of(j_q, i_q);
			end
			S_PRD: begin
				mem_re = 1'b1;
				mem_raddr = addr_of(k_q, i_q);
			end
			S_CRD: begin
				mem_re = 1'b1;
				mem_raddr = half_q ? addr_of(j_q, cnt_q) : addr_of(cnt_q, i_q);
			end
			S_CWR: begin
				col_we = !half_q;
				row_we = half_q;
			end
			S_ARD: col_re = 1'b1;
			S_ERD: begin
				row_re = 1'b1;
				mem_re = 1'b1;
			end
			S_EWR: mem_we = 1'b1;
			default: mem_we = 1'b0;
		endcase
	end

	// Product register of the shared multiplier.
	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
	end

	// Sequencer with its working and output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			det_q <= '0;
			ovalid_q <= 1'b0;
			second_q <= 1'b0;
			half_q <= 1'b0;
			sat_q <= 1'b0;
		end else begin
			if ((state_q == S_FIN) && (!ovalid_q || m_tready)) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q <= s_tuser;
						range_q <= in_range;
						i_q <= IW'(s_tdata[3:0]);
						col_q <= IW'(s_tdata[7:4]);
						k_q <= IW'(s_tdata[11:8]);
						wv_q <= s_tdata[43:12];
						delta_q <= s_tdata[75:44];
						d2_q <= s_tdata[107:76];
						j_q <= IW'(s_tdata[7:4]);
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					rv_q <= '0;
					st_q <= ST_OK;
					sat_q <= 1'b0;
					second_q <= 1'b0;
					state_q <= S_FIN;
					if (range_q) begin
						case (op_q)
							OP_WRITE_DET: det_q <= wv_q;
							OP_READ: state_q <= S_RDW;
							OP_SINGLE, OP_DOUBLE: state_q <= S_DRD;
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_RDW: begin
					rv_q <= mrd;
					state_q <= S_FIN;
				end
				S_DRD: state_q <= S_DMUL;
				S_DMUL: begin
					mji_q <= mrd;
					state_q <= S_DCHK;
				end
				// Divisor check; a zero divisor ends the item untouched.
				S_DCHK: begin
					if (dsat[31:0] == 32'h0) begin
						st_q <= ST_ZERO;
						state_q <= S_FIN;
					end else begin
						d_q <= dsat[31:0];
						sat_q <= sat_q | dsat[32];
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						s_q <= div_quot;
						sat_q <= sat_q | div_ovf;
						cnt_q <= '0;
						half_q <= 1'b0;
						if ((op_q == OP_DOUBLE) && !second_q) begin
							state_q <= S_PRD;
						end else begin
							state_q <= S_CRD;
						end
					end
				end
				// Look ahead at the second divisor before anything is written.
				S_PRD: state_q <= S_PM1;
				S_PM1: begin
					mki_q <= mrd;
					state_q <= S_PM2;
				end
				S_PM2: begin
					a_q <= psat[31:0];
					state_q <= S_PM3;
				end
				S_PM3: state_q <= S_PM4;
				S_PM4: begin
					m1_q <= lsat[31:0];
					state_q <= S_PM5;
				end
				S_PM5: state_q <= S_PM6;
				S_PM6: begin
					if (dsat[31:0] == 32'h0) begin
						st_q <= ST_ZERO;
						state_q <= S_FIN;
					end else begin
						state_q <= S_CRD;
					end
				end
				// Copy column i and row j into the buffers.
				S_CRD: state_q <= S_CWR;
				S_CWR: begin
					if (cnt_q == LAST) begin
						cnt_q <= '0;
						if (half_q) begin
							r_q <= '0;
							state_q <= S_ARD;
						end else begin
							half_q <= 1'b1;
							state_q <= S_CRD;
						end
					end else begin
						cnt_q <= cnt_q + IW'(1);
						state_q <= S_CRD;
					end
				end
				// Rewrite pass: each row forms its scale, then each entry is read, multiplied and written.
				S_ARD: state_q <= S_AMUL;
				S_AMUL: state_q <= S_ASAT;
				S_ASAT: begin
					a_q <= psat[31:0];
					sat_q <= sat_q | psat[32];
					c_q <= '0;
					state_q <= S_ERD;
				end
				S_ERD: state_q <= S_EMUL;
				S_EMUL: state_q <= S_EWR;
				S_EWR: begin
					sat_q <= sat_q | esat[32];
					if (c_q == LAST) begin
						if (r_q == LAST) begin
							state_q <= S_DET;
						end else begin
							r_q <= r_q + IW'(1);
							state_q <= S_ARD;
						end
					end else begin
						c_q <= c_q + IW'(1);
						state_q <= S_ERD;
					end
				end
				S_DET: state_q <= S_DETW;
				S_DETW: begin
					det_q <= psat[31:0];
					if ((op_q == OP_DOUBLE) && !second_q) begin
						sat_q <= sat_q | psat[32];
						second_q <= 1'b1;
						j_q <= k_q;
						delta_q <= d2_q;
						state_q <= S_DRD;
					end else begin
						st_q <= (sat_q | psat[32]) ? ST_SAT : ST_OK;
						state_q <= S_FIN;
					end
				end
				// Hand the result to the output register once it is free.
				S_FIN: begin
					if (!ovalid_q || m_tready) begin
						orv_q <= rv_q;
						ost_q <= st_q;
						odet_q <= det_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata = {odet_q, orv_q};
	assign m_tuser = ost_q;

endmodule

// ===== src/roiu_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank-one inverse update checker
// Port-level checks over time, bound to the top level.
// ----------------------------------------------------------------------------
module roiu_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [roiu_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [roiu_pkg::STAT_W-1:0]     m_tuser
);
	import roiu_pkg::*;

	// A stalled result beat stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// After a command beat the sequencer is busy in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command accepted while sequencer busy");

	// Status never carries the unused code.
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_ZERO || m_tuser == ST_SAT))
		else $error("illegal status code");

	// A skipped update reports no read value.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_ZERO) |-> (m_tdata[31:0] == 32'h0))
		else $error("read value on skipped update");

	// No result beat appears the cycle after a command is taken.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result beat without processing");

endmodule

bind rank_one_inverse_update roiu_chk u_roiu_chk (.*);

// ===== dv/tb_rank_one_inverse_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank-one inverse update testbench
// Loads the whole inverse, then runs directed and random commands through
// the stream ports with bursty input and a stalling receiver. Every result
// beat is checked against a Q16.16 Sherman-Morrison predictor kept here.
// ----------------------------------------------------------------------------
module tb_rank_one_inverse_update;
	import roiu_pkg::*;

	localparam int N = DIM_DEF;
	localparam int NUM_RANDOM = 1500;
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_LAST = 3'd7;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;
	localparam logic signed [31:0] MAX_V = 32'sh7fff_ffff;
	localparam logic signed [31:0] MIN_V = 32'sh8000_0000;

	typedef struct {
		logic [OP_W-1:0] op;
		logic [3:0] ri, ci, ki;
		logic signed [31:0] wv, d1, d2;
		bit wait_idle;
	} cmd_t;

	typedef struct {
		logic signed [31:0] rd, det;
		logic [STAT_W-1:0] status;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [OP_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0] m_tuser;

	rank_one_inverse_update #(.DIM(N)) dut (.*);

	// Predictor state: committed matrix and determinant, plus a work copy.
	logic signed [31:0] inv_mat [N*N];
	logic signed [31:0] inv_det = '0;
	logic signed [31:0] work_mat [N*N];
	logic signed [31:0] work_det;
	bit clamp_hit;

	cmd_t pending_cmds[$];
	result_t expected_results[$];
	cmd_t cur_cmd;
	int burst_left = 0;
	int gap_left = 0;
	int mismatches = 0;
	int results_seen = 0;

	initial forever #1 clk = ~clk;

	function automatic logic signed [63:0] round_q16(input logic signed [63:0] v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			clamp_hit = 1'b1;
			return MAX_V;
		end
		if (v < -64'sd2147483648) begin
			clamp_hit = 1'b1;
			return MIN_V;
		end
		return v[31:0];
	endfunction

	// One Sherman-Morrison step on the work copy; ok is low on a zero divisor.
	task automatic sm_step(input int i, input int j, input logic signed [31:0] delta,
			output bit ok);
		logic signed [31:0] dv, sc, a;
		logic signed [31:0] col [N];
		logic signed [31:0] row [N];
		logic signed [63:0] t;
		dv = clamp32(round_q16(64'sd4294967296 + 64'(delta) * 64'(work_mat[j*N+i])));
		ok = (dv != 0);
		if (ok) begin
			for (int r = 0; r < N; r++) col[r] = work_mat[r*N+i];
			for (int c = 0; c < N; c++) row[c] = work_mat[j*N+c];
			sc = clamp32((64'(delta) * 64'sd65536) / 64'(dv));
			for (int r = 0; r < N; r++) begin
				a = clamp32(round_q16(64'(sc) * 64'(col[r])));
				for (int c = 0; c < N; c++) begin
					t = round_q16(64'(a) * 64'(row[c]));
					work_mat[r*N+c] = clamp32(64'(work_mat[r*N+c]) - t);
				end
			end
			work_det = clamp32(round_q16(64'(work_det) * 64'(dv)));
		end
	endtask

	// Applies one accepted command to the predictor and queues its result.
	task automatic apply_command(input cmd_t cmd);
		result_t res;
		bit ok;
		res.rd = '0;
		res.status = ST_OK;
		clamp_hit = 1'b0;
		case (cmd.op)
			OP_WRITE_ENTRY: inv_mat[cmd.ri*N+cmd.ci] = cmd.wv;
			OP_WRITE_DET: inv_det = cmd.wv;
			OP_READ: res.rd = inv_mat[cmd.ri*N+cmd.ci];
			OP_SINGLE, OP_DOUBLE: begin
				work_mat = inv_mat;
				work_det = inv_det;
				sm_step(cmd.ri, cmd.ci, cmd.d1, ok);
				if (ok && cmd.op == OP_DOUBLE) sm_step(cmd.ri, cmd.ki, cmd.d2, ok);
				if (ok) begin
					inv_mat = work_mat;
					inv_det = work_det;
					res.status = clamp_hit ? ST_SAT : ST_OK;
				end else begin
					res.status = ST_ZERO;
				end
			end
			default: ;
		endcase
		res.det = inv_det;
		expected_results.push_back(res);
	endtask

	function automatic cmd_t mk(input logic [OP_W-1:0] op, input int ri, input int ci,
			input int ki, input logic signed [31:0] wv, input logic signed [31:0] d1,
			input logic signed [31:0] d2);
		cmd_t c;
		c.op = op;
		c.ri = ri[3:0];
		c.ci = ci[3:0];
		c.ki = ki[3:0];
		c.wv = wv;
		c.d1 = d1;
		c.d2 = d2;
		c.wait_idle = 1'b0;
		return c;
	endfunction

	// Mostly small Q16.16 values, sometimes any 32-bit pattern.
	function automatic logic signed [31:0] rand_val(input int span);
		if ($urandom_range(9) == 0) return $urandom;
		return $signed($urandom_range(2*span)) - span;
	endfunction

	// Driver: bursts of beats with random gaps; holds a beat until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) apply_command(cur_cmd);
			if (s_tvalid && !s_tready) begin
				s_tvalid <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_cmds.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (pending_cmds[0].wait_idle && expected_results.size() != 0) begin
				s_tvalid <= 1'b0;
			end else begin
				cur_cmd = pending_cmds.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= cur_cmd.op;
				s_tdata <= {4'b0, cur_cmd.d2, cur_cmd.d1, cur_cmd.wv,
					cur_cmd.ki, cur_cmd.ci, cur_cmd.ri};
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(30);
					gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
				end
			end
		end
	end

	// Receiver: a randomly chosen ready pattern, redrawn whenever the phase counter wraps, plus one long hold-off.
	int ready_phase = 0;
	int ready_mode = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	always @(posedge clk) begin
		if (!hold_done && results_seen == 300) begin
			hold_done = 1'b1;
			hold_left = 3000;
		end
		if (ready_phase == 0) ready_mode = $urandom_range(2);
		ready_phase = (ready_phase + 1) % 64;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (ready_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(1);
				default: m_tready <= ($urandom_range(4) == 0);
			endcase
		end
	end

	// Monitor: compares each result beat with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %h/%h", m_tdata, m_tuser);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[31:0] !== want.rd || m_tdata[63:32] !== want.det
						|| m_tuser !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected rd %h det %h st %0d, got rd %h det %h st %0d",
							want.rd, want.det, want.status,
							m_tdata[31:0], m_tdata[63:32], m_tuser);
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		cmd_t c;
		int op_pick;
		// Load the full inverse so no entry is ever used unwritten.
		for (int i = 0; i < N; i++)
			for (int j = 0; j < N; j++)
				pending_cmds.push_back(mk(OP_WRITE_ENTRY, i, j, 0,
					(i == j) ? ONE : rand_val(32'h4000), 0, 0));
		pending_cmds.push_back(mk(OP_WRITE_DET, 0, 0, 0, ONE, 0, 0));

		// Directed: extremes, every op, zero divisor in each step, saturation.
		pending_cmds.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk(OP_READ, 15, 15, 0, 0, 0, 0));
		pending_cmds.push_back(mk(OP_SINGLE, 3, 3, 0, 0, 0, 0));
		pending_cmds.push_back(mk(OP_SINGLE, 2, 2, 0, 0, -ONE, 0));
		pending_cmds.push_back(mk(OP_DOUBLE, 4, 5, 4, 0, 0, -ONE));
		pending_cmds.push_back(mk(OP_DOUBLE, 6, 6, 7, 0, ONE >>> 2, -(ONE >>> 3)));
		pending_cmds.push_back(mk(OP_WRITE_ENTRY, 15, 0, 0, MAX_V, 0, 0));
		pending_cmds.push_back(mk(OP_WRITE_ENTRY, 0, 15, 0, MIN_V, 0, 0));
		pending_cmds.push_back(mk(OP_READ, 15, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk(OP_READ, 0, 15, 0, 0, 0, 0));
		pending_cmds.push_back(mk(OP_WRITE_DET, 0, 0, 0, MAX_V, 0, 0));
		pending_cmds.push_back(mk(OP_SINGLE, 0, 0, 0, 0, MAX_V, 0));
		pending_cmds.push_back(mk(OP_WRITE_DET, 0, 0, 0, MIN_V, 0, 0));
		pending_cmds.push_back(mk(OP_DOUBLE, 15, 15, 0, 0, MIN_V, MAX_V));
		for (logic [OP_W-1:0] o = OP_SPARE_FIRST; o <= OP_SPARE_LAST && o != 0; o++)
			pending_cmds.push_back(mk(o, 1, 2, 3, MAX_V, MIN_V, MAX_V));
		// Sender pause: wait until every result is back, then restore the inverse.
		c = mk(OP_WRITE_DET, 0, 0, 0, ONE, 0, 0);
		c.wait_idle = 1'b1;
		pending_cmds.push_back(c);
		for (int i = 0; i < N; i++)
			for (int j = 0; j < N; j++)
				pending_cmds.push_back(mk(OP_WRITE_ENTRY, i, j, 0,
					(i == j) ? ONE : rand_val(32'h2000), 0, 0));

		// Random commands.
		for (int n = 0; n < NUM_RANDOM; n++) begin
			op_pick = $urandom_range(99);
			c = mk(OP_READ, $urandom_range(15), $urandom_range(15), $urandom_range(15),
				rand_val(32'h2_0000), rand_val(32'h1_0000), rand_val(32'h1_0000));
			if (op_pick < 35) c.op = OP_WRITE_ENTRY;
			else if (op_pick < 40) c.op = OP_WRITE_DET;
			else if (op_pick < 48) c.op = OP_SINGLE;
			else if (op_pick < 52) c.op = OP_DOUBLE;
			else if (op_pick < 92) c.op = OP_READ;
			else c.op = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
			if (n == 1200) c.wait_idle = 1'b1;
			pending_cmds.push_back(c);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_cmds.size() == 0 && !s_tvalid);
		wait (expected_results.size() == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#8_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
